// ===== design/tiny_register_machine_execute_assert.svh =====
// assertion macros shared by the execute block
`ifndef TINY_REGISTER_MACHINE_EXECUTE_ASSERT_SVH
`define TINY_REGISTER_MACHINE_EXECUTE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define TRME_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define TRME_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/trme_pkg.sv =====
// shared constants and types of the register machine execute block
package trme_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int MEM_WORDS  = 256;
    localparam int MEM_AW     = $clog2(MEM_WORDS);
    localparam int NUM_REGS   = 8;
    localparam int REG_AW     = 3;
    localparam int INSTR_W    = 8;
    localparam int CNT_W      = 16;
    localparam int OUT_DEPTH  = 4;
    localparam int OUT_AW     = $clog2(OUT_DEPTH);
    localparam int PEND_W     = $clog2(OUT_DEPTH + 1);

    // register contents after reset
    localparam logic [DATA_WIDTH-1:0] REG_RESET [NUM_REGS] = '{
        DATA_WIDTH'(0), DATA_WIDTH'(4), DATA_WIDTH'(9), DATA_WIDTH'(10),
        DATA_WIDTH'(0), DATA_WIDTH'(0), DATA_WIDTH'(0), DATA_WIDTH'(0)
    };

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_SUB   = 2'd1,
        OP_LOAD  = 2'd2,
        OP_STORE = 2'd3
    } t_op;

    // register file write port
    typedef struct packed {
        logic                  en;
        logic [REG_AW-1:0]     idx;
        logic [DATA_WIDTH-1:0] data;
    } t_rf_wr;

    // one result item
    typedef struct packed {
        logic [CNT_W-1:0]      instr_addr;
        t_op                   op_kind;
        logic [REG_AW-1:0]     dest_reg;
        logic                  reg_written;
        logic [DATA_WIDTH-1:0] reg_value;
        logic                  mem_written;
        logic [DATA_WIDTH-1:0] mem_addr;
        logic [DATA_WIDTH-1:0] mem_value;
        logic                  addr_error;
    } t_result;

endpackage

// ===== design/tiny_register_machine_execute.sv =====
// top level of the register machine execute block
//
// Input channel: i_valid / o_stall carry one 8-bit instruction per transfer.
// Output channel: o_valid / i_stall carry one result per instruction, in order.
// Pipeline: an accepted instruction goes through register read, execute and
// memory access, and writeback into the result queue before its result can
// be taken.
// Throughput: one instruction per cycle while o_stall is low, set by the register
// file read ports and the data memory port; back-to-back dependences are served by
// forwarding from the writeback stage and from the last write.
// Up to four instructions may be accepted and not yet taken; o_stall rises
// when that many are outstanding and falls at the cycle after a result
// transfer frees a slot. A stalled receiver thus holds results in the queue
// while execution carries on for the ones already in flight.
// Reset: registers read 0,4,9,10,0,0,0,0, data memory reads all zeros and the
// sequence number restarts at zero; the block accepts in the first cycle
// after reset, as the cleared state is kept by per-entry written flags.
`include "tiny_register_machine_execute_assert.svh"

module tiny_register_machine_execute (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic [trme_pkg::INSTR_W-1:0]           i_instruction,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic [trme_pkg::CNT_W-1:0]             o_instr_addr,
    output logic [1:0]                             o_op_kind,
    output logic [trme_pkg::REG_AW-1:0]            o_dest_reg,
    output logic                                   o_reg_written,
    output logic signed [trme_pkg::DATA_WIDTH-1:0] o_reg_value,
    output logic                                   o_mem_written,
    output logic signed [trme_pkg::DATA_WIDTH-1:0] o_mem_addr,
    output logic signed [trme_pkg::DATA_WIDTH-1:0] o_mem_value,
    output logic                                   o_addr_error
);

    logic                              in_xfer;
    logic                              out_xfer;
    logic [trme_pkg::CNT_W-1:0]        r_icnt;
    logic [trme_pkg::PEND_W-1:0]       r_pend;

    // execute stage
    logic                              r_s1_vld;
    trme_pkg::t_op                     r_s1_op;
    logic [trme_pkg::REG_AW-1:0]       r_s1_r1;
    logic [trme_pkg::REG_AW-1:0]       r_s1_r2;
    logic [trme_pkg::CNT_W-1:0]        r_s1_cnt;
    logic [trme_pkg::DATA_WIDTH-1:0]   rf_a;
    logic [trme_pkg::DATA_WIDTH-1:0]   rf_b;
    logic [trme_pkg::DATA_WIDTH-1:0]   op_a;
    logic [trme_pkg::DATA_WIDTH-1:0]   op_b;
    logic                              in_range;
    logic                              s1_oob_store;
    trme_pkg::t_result                 n_s2;

    // writeback stage
    logic                              r_s2_vld;
    trme_pkg::t_result                 r_s2;
    logic [trme_pkg::DATA_WIDTH-1:0]   s2_reg_value;
    trme_pkg::t_rf_wr                  wb;
    logic                              r_byp_vld;
    logic [trme_pkg::REG_AW-1:0]       r_byp_idx;
    logic [trme_pkg::DATA_WIDTH-1:0]   r_byp_val;

    // data memory
    logic [trme_pkg::DATA_WIDTH-1:0]   r_dmem [trme_pkg::MEM_WORDS];
    logic [trme_pkg::MEM_WORDS-1:0]    r_dmem_vld;
    logic [trme_pkg::DATA_WIDTH-1:0]   r_dm_q;
    logic                              r_dm_qv;
    logic [trme_pkg::MEM_AW-1:0]       dm_idx;
    logic                              dm_we;

    // result queue
    trme_pkg::t_result                 r_fifo [trme_pkg::OUT_DEPTH];
    logic [trme_pkg::OUT_AW-1:0]       r_wr_ptr;
    logic [trme_pkg::OUT_AW-1:0]       r_rd_ptr;
    logic [trme_pkg::PEND_W-1:0]       r_fcnt;
    trme_pkg::t_result                 head;
    trme_pkg::t_result                 push_item;

    // handshakes: stall only on the count of outstanding instructions
    assign o_stall  = (r_pend == (trme_pkg::PEND_W)'(trme_pkg::OUT_DEPTH));
    assign in_xfer  = i_valid && !o_stall;
    assign o_valid  = (r_fcnt != '0);
    assign out_xfer = o_valid && !i_stall;

    // outstanding count and sequence number
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_icnt <= '0;
        end else begin
            r_pend <= r_pend + (trme_pkg::PEND_W)'(in_xfer)
                      - (trme_pkg::PEND_W)'(out_xfer);
            if (in_xfer) begin
                r_icnt <= r_icnt + 1'b1;
            end
        end
    end

    // register file, read at the transfer edge
    trme_regfile u_regfile (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_idx_a  (i_instruction[5:3]),
        .i_rd_idx_b  (i_instruction[2:0]),
        .i_wr        (wb),
        .o_rd_data_a (rf_a),
        .o_rd_data_b (rf_b)
    );

    // decode register for the execute stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= in_xfer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_op  <= trme_pkg::t_op'(i_instruction[7:6]);
            r_s1_r1  <= i_instruction[5:3];
            r_s1_r2  <= i_instruction[2:0];
            r_s1_cnt <= r_icnt;
        end
    end

    // operand forwarding: writeback in flight first, then the write the ram read missed
    always_comb begin
        if (wb.en && (wb.idx == r_s1_r1)) begin
            op_a = wb.data;
        end else if (r_byp_vld && (r_byp_idx == r_s1_r1)) begin
            op_a = r_byp_val;
        end else begin
            op_a = rf_a;
        end
        if (wb.en && (wb.idx == r_s1_r2)) begin
            op_b = wb.data;
        end else if (r_byp_vld && (r_byp_idx == r_s1_r2)) begin
            op_b = r_byp_val;
        end else begin
            op_b = rf_b;
        end
    end

    // address check: non-negative and below the memory size
    assign in_range = !op_b[trme_pkg::DATA_WIDTH-1]
                      && (64'(op_b) < 64'(trme_pkg::MEM_WORDS));
    assign dm_idx   = (trme_pkg::MEM_AW)'(op_b);
    assign dm_we    = r_s1_vld && (r_s1_op == trme_pkg::OP_STORE) && in_range;
    assign s1_oob_store = r_s1_vld && (r_s1_op == trme_pkg::OP_STORE) && !in_range;

    // execute: alu result and memory side fields
    always_comb begin
        n_s2             = '0;
        n_s2.instr_addr  = r_s1_cnt;
        n_s2.op_kind     = r_s1_op;
        n_s2.dest_reg    = r_s1_r1;
        unique case (r_s1_op)
            trme_pkg::OP_ADD: begin
                n_s2.reg_written = 1'b1;
                n_s2.reg_value   = op_a + op_b;
            end
            trme_pkg::OP_SUB: begin
                n_s2.reg_written = 1'b1;
                n_s2.reg_value   = op_a - op_b;
            end
            trme_pkg::OP_LOAD: begin
                n_s2.reg_written = 1'b1;
                n_s2.mem_addr    = op_b;
                n_s2.addr_error  = !in_range;
            end
            trme_pkg::OP_STORE: begin
                n_s2.mem_addr    = op_b;
                n_s2.mem_value   = op_a;
                n_s2.mem_written = in_range;
                n_s2.addr_error  = !in_range;
            end
        endcase
    end

    // data memory array, read data registered
    always_ff @(posedge i_clk) begin
        if (dm_we) begin
            r_dmem[dm_idx] <= op_a;
        end
        r_dm_q <= r_dmem[dm_idx];
    end

    // data memory written flags, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dmem_vld <= '0;
            r_dm_qv    <= 1'b0;
        end else begin
            if (dm_we) begin
                r_dmem_vld[dm_idx] <= 1'b1;
            end
            r_dm_qv <= r_dmem_vld[dm_idx];
        end
    end

    // writeback stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_vld) begin
            r_s2 <= n_s2;
        end
    end

    // load data: all ones out of range, zero for a word never stored
    always_comb begin
        if (r_s2.op_kind == trme_pkg::OP_LOAD) begin
            if (r_s2.addr_error) begin
                s2_reg_value = '1;
            end else if (r_dm_qv) begin
                s2_reg_value = r_dm_q;
            end else begin
                s2_reg_value = '0;
            end
        end else begin
            s2_reg_value = r_s2.reg_value;
        end
    end

    // register write port
    assign wb.en   = r_s2_vld && r_s2.reg_written;
    assign wb.idx  = r_s2.dest_reg;
    assign wb.data = s2_reg_value;

    // remember the last write for the instruction whose read coincided with it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp_vld <= 1'b0;
        end else begin
            r_byp_vld <= wb.en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byp_idx <= wb.idx;
        r_byp_val <= wb.data;
    end

    // result queue
    always_comb begin
        push_item           = r_s2;
        push_item.reg_value = s2_reg_value;
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_vld) begin
            r_fifo[r_wr_ptr] <= push_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fcnt   <= '0;
        end else begin
            if (r_s2_vld) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (out_xfer) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_fcnt <= r_fcnt + (trme_pkg::PEND_W)'(r_s2_vld)
                      - (trme_pkg::PEND_W)'(out_xfer);
        end
    end

    // result fields from the queue head
    assign head          = r_fifo[r_rd_ptr];
    assign o_instr_addr  = head.instr_addr;
    assign o_op_kind     = head.op_kind;
    assign o_dest_reg    = head.dest_reg;
    assign o_reg_written = head.reg_written;
    assign o_reg_value   = head.reg_value;
    assign o_mem_written = head.mem_written;
    assign o_mem_addr    = head.mem_addr;
    assign o_mem_value   = head.mem_value;
    assign o_addr_error  = head.addr_error;

    // checks
    `TRME_ASSERT_IMPL(a_pend_matches, 1'b1,
        r_pend == ((trme_pkg::PEND_W)'(r_s1_vld) + (trme_pkg::PEND_W)'(r_s2_vld) + r_fcnt),
        "outstanding count out of step with pipeline and queue")
    `TRME_ASSERT_NEXT(a_oob_store_blocked, s1_oob_store,
        r_s2_vld && r_s2.addr_error && !r_s2.mem_written,
        "out of range store reported as written")
    `TRME_ASSERT_IMPL(a_oob_load_ones,
        r_s2_vld && (r_s2.op_kind == trme_pkg::OP_LOAD) && r_s2.addr_error,
        wb.en && (s2_reg_value == '1),
        "out of range load did not write all ones")
    `TRME_ASSERT_NEXT(a_transfer_enters, in_xfer, r_s1_vld,
        "accepted instruction did not enter execute")

endmodule

// ===== design/trme_regfile.sv =====
// register file: synchronous ram, two read ports, one write port, reset values by valid bits
module trme_regfile (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [trme_pkg::REG_AW-1:0]         i_rd_idx_a,
    input  logic [trme_pkg::REG_AW-1:0]         i_rd_idx_b,
    input  trme_pkg::t_rf_wr                    i_wr,
    output logic [trme_pkg::DATA_WIDTH-1:0]     o_rd_data_a,
    output logic [trme_pkg::DATA_WIDTH-1:0]     o_rd_data_b
);

    logic [trme_pkg::DATA_WIDTH-1:0] r_rf [trme_pkg::NUM_REGS];
    logic [trme_pkg::NUM_REGS-1:0]   r_rf_vld;
    logic [trme_pkg::DATA_WIDTH-1:0] r_q_a;
    logic [trme_pkg::DATA_WIDTH-1:0] r_q_b;
    logic                            r_v_a;
    logic                            r_v_b;
    logic [trme_pkg::REG_AW-1:0]     r_idx_a;
    logic [trme_pkg::REG_AW-1:0]     r_idx_b;

    // storage array, read data registered (old data on a same-cycle write)
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_rf[i_wr.idx] <= i_wr.data;
        end
        r_q_a   <= r_rf[i_rd_idx_a];
        r_q_b   <= r_rf[i_rd_idx_b];
        r_idx_a <= i_rd_idx_a;
        r_idx_b <= i_rd_idx_b;
    end

    // written flags, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rf_vld <= '0;
            r_v_a    <= 1'b0;
            r_v_b    <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_rf_vld[i_wr.idx] <= 1'b1;
            end
            r_v_a <= r_rf_vld[i_rd_idx_a];
            r_v_b <= r_rf_vld[i_rd_idx_b];
        end
    end

    // never-written entries read as their reset value
    assign o_rd_data_a = r_v_a ? r_q_a : trme_pkg::REG_RESET[r_idx_a];
    assign o_rd_data_b = r_v_b ? r_q_b : trme_pkg::REG_RESET[r_idx_b];

endmodule
